FILE: hw/rtl/tcce_pkg.sv
package tcce_pkg;

   // character codes with fixed handling
   localparam logic [7:0]  CODE_TAB     = 8'h09;
   localparam logic [7:0]  CODE_NEWLINE = 8'h0A;
   localparam logic [7:0]  CODE_SPACE   = 8'h20;

   // reset contents of every screen cell and reset register values
   localparam logic [15:0] RESET_CELL      = 16'h0720;
   localparam logic [7:0]  RESET_COLOR     = 8'h07;
   localparam logic [7:0]  RESET_BACKSPACE = 8'h08;

   // microprogram step addresses
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_CHAR,
      ST_TAB_PUT,
      ST_TAB_NEXT,
      ST_NEWLINE,
      ST_BACK,
      ST_BACK_PUT,
      ST_READ,
      ST_READ_OUT,
      ST_EMIT,
      ST_SCR_INIT,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCR_BLANK,
      ST_SCR_RET
   } step_type;

   // screen write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_RESET,
      WR_CHAR,
      WR_SPACE,
      WR_COPY,
      WR_BLANK
   } wr_sel_type;

   // cursor update
   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_LINE_FEED,
      CUR_STEP_BACK
   } cur_op_type;

   // screen read address source
   typedef enum logic {
      RD_ADDR,
      RD_COPY
   } rd_sel_type;

   // sweep pointer update
   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_INCR
   } ptr_op_type;

   // next step selection
   typedef enum logic [1:0] {
      JMP_GOTO,
      JMP_COND,
      JMP_DISPATCH,
      JMP_RET
   } jump_type;

   // branch conditions
   typedef enum logic [2:0] {
      COND_PTR_MORE,
      COND_COPY_MORE,
      COND_TAB_MORE,
      COND_ADV_SCROLL,
      COND_LF_SCROLL
   } cond_type;

   // decoded kind of an incoming item
   typedef enum logic [2:0] {
      KIND_READ,
      KIND_TAB,
      KIND_NEWLINE,
      KIND_BACKSPACE,
      KIND_CHAR
   } kind_type;

   // one control word of the microprogram
   typedef struct packed {
      wr_sel_type wr;
      cur_op_type cur;
      rd_sel_type rd;
      ptr_op_type ptr;
      logic       cnt_dec;
      logic       fetch;
      logic       emit;
      logic       emit_cell;
      logic       save_ret;
      jump_type   jump;
      cond_type   cond;
      step_type   target;
      step_type   alt;
      step_type   ret;
   } uword_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic     accept;
      kind_type kind;
      logic     ptr_more;
      logic     copy_more;
      logic     tab_more;
      logic     adv_scroll;
      logic     lf_scroll;
   } seq_flags_type;

   // sequencer status back to the datapath
   typedef struct packed {
      logic exec;
      logic emit;
   } seq_status_type;

endpackage

FILE: hw/rtl/tcce_useq.sv
module tcce_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  tcce_pkg::seq_flags_type flags,
   input  logic                    out_busy,
   output tcce_pkg::uword_type     ctl,
   output tcce_pkg::seq_status_type status
);

   tcce_pkg::step_type step_ff, step_in;
   tcce_pkg::step_type ret_ff, ret_in;
   tcce_pkg::step_type dispatch_step;
   logic               cond_true;
   logic               emit_eff;
   logic               stall;

   // control store
   function automatic tcce_pkg::uword_type urom(input tcce_pkg::step_type s);
      tcce_pkg::uword_type w;
      w.wr        = tcce_pkg::WR_NONE;
      w.cur       = tcce_pkg::CUR_HOLD;
      w.rd        = tcce_pkg::RD_ADDR;
      w.ptr       = tcce_pkg::PTR_HOLD;
      w.cnt_dec   = 1'b0;
      w.fetch     = 1'b0;
      w.emit      = 1'b0;
      w.emit_cell = 1'b0;
      w.save_ret  = 1'b0;
      w.jump      = tcce_pkg::JMP_GOTO;
      w.cond      = tcce_pkg::COND_PTR_MORE;
      w.target    = tcce_pkg::ST_FETCH;
      w.alt       = tcce_pkg::ST_FETCH;
      w.ret       = tcce_pkg::ST_FETCH;
      case (s)
         tcce_pkg::ST_CLEAR: begin
            w.wr     = tcce_pkg::WR_RESET;
            w.ptr    = tcce_pkg::PTR_INCR;
            w.jump   = tcce_pkg::JMP_COND;
            w.cond   = tcce_pkg::COND_PTR_MORE;
            w.target = tcce_pkg::ST_CLEAR;
            w.alt    = tcce_pkg::ST_FETCH;
         end
         tcce_pkg::ST_FETCH: begin
            w.fetch = 1'b1;
            w.jump  = tcce_pkg::JMP_DISPATCH;
         end
         tcce_pkg::ST_CHAR: begin
            w.wr       = tcce_pkg::WR_CHAR;
            w.cur      = tcce_pkg::CUR_ADVANCE;
            w.emit     = 1'b1;
            w.jump     = tcce_pkg::JMP_COND;
            w.cond     = tcce_pkg::COND_ADV_SCROLL;
            w.target   = tcce_pkg::ST_SCR_INIT;
            w.alt      = tcce_pkg::ST_FETCH;
            w.save_ret = 1'b1;
            w.ret      = tcce_pkg::ST_EMIT;
         end
         tcce_pkg::ST_TAB_PUT: begin
            w.wr       = tcce_pkg::WR_SPACE;
            w.cur      = tcce_pkg::CUR_ADVANCE;
            w.jump     = tcce_pkg::JMP_COND;
            w.cond     = tcce_pkg::COND_ADV_SCROLL;
            w.target   = tcce_pkg::ST_SCR_INIT;
            w.alt      = tcce_pkg::ST_TAB_NEXT;
            w.save_ret = 1'b1;
            w.ret      = tcce_pkg::ST_TAB_NEXT;
         end
         tcce_pkg::ST_TAB_NEXT: begin
            w.cnt_dec = 1'b1;
            w.jump    = tcce_pkg::JMP_COND;
            w.cond    = tcce_pkg::COND_TAB_MORE;
            w.target  = tcce_pkg::ST_TAB_PUT;
            w.alt     = tcce_pkg::ST_EMIT;
         end
         tcce_pkg::ST_NEWLINE: begin
            w.cur      = tcce_pkg::CUR_LINE_FEED;
            w.emit     = 1'b1;
            w.jump     = tcce_pkg::JMP_COND;
            w.cond     = tcce_pkg::COND_LF_SCROLL;
            w.target   = tcce_pkg::ST_SCR_INIT;
            w.alt      = tcce_pkg::ST_FETCH;
            w.save_ret = 1'b1;
            w.ret      = tcce_pkg::ST_EMIT;
         end
         tcce_pkg::ST_BACK: begin
            w.cur    = tcce_pkg::CUR_STEP_BACK;
            w.target = tcce_pkg::ST_BACK_PUT;
         end
         tcce_pkg::ST_BACK_PUT: begin
            w.wr   = tcce_pkg::WR_SPACE;
            w.emit = 1'b1;
         end
         tcce_pkg::ST_READ: begin
            w.rd     = tcce_pkg::RD_ADDR;
            w.target = tcce_pkg::ST_READ_OUT;
         end
         tcce_pkg::ST_READ_OUT: begin
            w.emit      = 1'b1;
            w.emit_cell = 1'b1;
         end
         tcce_pkg::ST_EMIT: begin
            w.emit = 1'b1;
         end
         tcce_pkg::ST_SCR_INIT: begin
            w.ptr    = tcce_pkg::PTR_CLEAR;
            w.target = tcce_pkg::ST_SCR_RD;
         end
         tcce_pkg::ST_SCR_RD: begin
            w.rd     = tcce_pkg::RD_COPY;
            w.target = tcce_pkg::ST_SCR_WR;
         end
         tcce_pkg::ST_SCR_WR: begin
            w.wr     = tcce_pkg::WR_COPY;
            w.ptr    = tcce_pkg::PTR_INCR;
            w.jump   = tcce_pkg::JMP_COND;
            w.cond   = tcce_pkg::COND_COPY_MORE;
            w.target = tcce_pkg::ST_SCR_RD;
            w.alt    = tcce_pkg::ST_SCR_BLANK;
         end
         tcce_pkg::ST_SCR_BLANK: begin
            w.wr     = tcce_pkg::WR_BLANK;
            w.ptr    = tcce_pkg::PTR_INCR;
            w.jump   = tcce_pkg::JMP_COND;
            w.cond   = tcce_pkg::COND_PTR_MORE;
            w.target = tcce_pkg::ST_SCR_BLANK;
            w.alt    = tcce_pkg::ST_SCR_RET;
         end
         tcce_pkg::ST_SCR_RET: begin
            w.jump = tcce_pkg::JMP_RET;
         end
         default: begin
            w.jump = tcce_pkg::JMP_GOTO;
         end
      endcase
      return w;
   endfunction

   assign ctl = urom(step_ff);

   always_comb begin
      case (ctl.cond)
         tcce_pkg::COND_PTR_MORE:   cond_true = flags.ptr_more;
         tcce_pkg::COND_COPY_MORE:  cond_true = flags.copy_more;
         tcce_pkg::COND_TAB_MORE:   cond_true = flags.tab_more;
         tcce_pkg::COND_ADV_SCROLL: cond_true = flags.adv_scroll;
         tcce_pkg::COND_LF_SCROLL:  cond_true = flags.lf_scroll;
         default:                   cond_true = 1'b0;
      endcase
   end

   always_comb begin
      case (flags.kind)
         tcce_pkg::KIND_READ:      dispatch_step = tcce_pkg::ST_READ;
         tcce_pkg::KIND_TAB:       dispatch_step = tcce_pkg::ST_TAB_PUT;
         tcce_pkg::KIND_NEWLINE:   dispatch_step = tcce_pkg::ST_NEWLINE;
         tcce_pkg::KIND_BACKSPACE: dispatch_step = tcce_pkg::ST_BACK;
         default:                  dispatch_step = tcce_pkg::ST_CHAR;
      endcase
   end

   // a result goes out unless the step takes its branch
   assign emit_eff = ctl.emit && !((ctl.jump == tcce_pkg::JMP_COND) && cond_true);
   assign stall    = emit_eff && out_busy;

   assign status.exec = !stall;
   assign status.emit = emit_eff && !stall;

   always_comb begin
      step_in = step_ff;
      ret_in  = ret_ff;
      if (!stall) begin
         if (ctl.save_ret) begin
            ret_in = ctl.ret;
         end
         case (ctl.jump)
            tcce_pkg::JMP_GOTO:     step_in = ctl.target;
            tcce_pkg::JMP_COND:     step_in = cond_true ? ctl.target : ctl.alt;
            tcce_pkg::JMP_DISPATCH: step_in = flags.accept ? dispatch_step : step_ff;
            tcce_pkg::JMP_RET:      step_in = ret_ff;
            default:                step_in = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tcce_pkg::ST_CLEAR;
         ret_ff  <= tcce_pkg::ST_FETCH;
      end else begin
         step_ff <= step_in;
         ret_ff  <= ret_in;
      end
   end

endmodule

FILE: hw/rtl/text_console_char_engine_core.sv
// text console engine: screen of character cells with a cursor
// req channel: one item per transfer; req_tuser selects put character (0)
//   or read cell (1); req_tdata carries the character and the cell address
// rsp channel: exactly one result per item, in order: cursor column and
//   row after the item, and the cell read (zero for a put)
// csr port: text_color at address 0, backspace_code at address 4
// microprogram steps per item, over a screen memory with one write port
//   and one registered read port (one write and one registered read per
//   cycle): ordinary character fetch, char; newline fetch, newline;
//   backspace fetch, back, back_put; read fetch, read, read_out;
//   tab fetch, tab_put and tab_next for each of TAB_WIDTH spaces, then emit
// a scroll walks the screen memory: copies rows up, blanks the bottom row
// the result is registered and shows on rsp the cycle after the last step
// reset: cursor to top-left, registers to defaults, then a clearing pass
//   fills every cell of the screen with grey spaces; req_tready stays low
//   until it ends
// a stalled rsp holds its result; the engine takes the next item meanwhile
//   and waits only when it has a second result to deliver
module text_console_char_engine_core #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_WIDTH     = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code [7:0], cell_address [18:8]
   input  logic        req_tuser,   // req_type
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_col [6:0], cursor_line [11:7],
                                    // cell_value [27:12]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_LAST = SCREEN_WIDTH * (SCREEN_HEIGHT - 1) - 1;
   localparam int AW        = $clog2(CELLS);
   localparam int COL_W     = $clog2(SCREEN_WIDTH);
   localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
   localparam int CNT_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

   // register select by address bit 2
   localparam logic REG_TEXT_COLOR = 1'b0;
   localparam logic REG_BACKSPACE  = 1'b1;

   tcce_pkg::uword_type      ctl;
   tcce_pkg::seq_status_type status;
   tcce_pkg::seq_flags_type  flags;
   tcce_pkg::kind_type       kind;

   logic [7:0]       color_ff;
   logic [7:0]       bs_code_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [7:0]       char_ff;
   logic [10:0]      addr_ff;
   logic [15:0]      rdata_ff;

   logic             rsp_valid_ff;
   logic [6:0]       rsp_col_ff;
   logic [4:0]       rsp_line_ff;
   logic [15:0]      rsp_cell_ff;

   logic [15:0]      screen_mem [CELLS];
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [15:0]      mem_wd;
   logic [AW-1:0]    mem_ra;
   logic [AW-1:0]    cur_addr;

   logic             req_xfer;
   logic             csr_write;
   logic             addr_ok;
   logic             row_last;

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   tcce_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .flags    (flags),
      .out_busy (rsp_valid_ff && !rsp_tready),
      .ctl      (ctl),
      .status   (status)
   );

   assign req_tready = ctl.fetch;
   assign req_xfer   = req_tvalid && req_tready;

   // item decode; tab and newline win over a matching backspace code
   always_comb begin
      if (req_tuser) begin
         kind = tcce_pkg::KIND_READ;
      end else if (req_tdata[7:0] == tcce_pkg::CODE_TAB) begin
         kind = tcce_pkg::KIND_TAB;
      end else if (req_tdata[7:0] == tcce_pkg::CODE_NEWLINE) begin
         kind = tcce_pkg::KIND_NEWLINE;
      end else if (req_tdata[7:0] == bs_code_ff) begin
         kind = tcce_pkg::KIND_BACKSPACE;
      end else begin
         kind = tcce_pkg::KIND_CHAR;
      end
   end

   assign row_last = (row_ff == ROW_LAST);

   assign flags.accept     = req_xfer;
   assign flags.kind       = kind;
   assign flags.ptr_more   = (ptr_ff != AW'(CELLS - 1));
   assign flags.copy_more  = (ptr_ff != AW'(COPY_LAST));
   assign flags.tab_more   = (cnt_ff != '0);
   assign flags.adv_scroll = (col_ff == COL_LAST) && row_last;
   assign flags.lf_scroll  = row_last;

   // ---------------------------------------------------------------
   // cursor
   // ---------------------------------------------------------------
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (status.exec) begin
         case (ctl.cur)
            tcce_pkg::CUR_ADVANCE: begin
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  if (!row_last) begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            tcce_pkg::CUR_LINE_FEED: begin
               // at the bottom row the scroll leaves the row as is
               col_in = '0;
               if (!row_last) begin
                  row_in = row_ff + 1'b1;
               end
            end
            tcce_pkg::CUR_STEP_BACK: begin
               // top-left stays put
               if (col_ff == '0) begin
                  if (row_ff != '0) begin
                     col_in = COL_LAST;
                     row_in = row_ff - 1'b1;
                  end
               end else begin
                  col_in = col_ff - 1'b1;
               end
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   assign cur_addr = AW'(row_ff * SCREEN_WIDTH + col_ff);

   // ---------------------------------------------------------------
   // sweep pointer: clearing pass and scroll copy
   // ---------------------------------------------------------------
   always_comb begin
      ptr_in = ptr_ff;
      if (status.exec) begin
         case (ctl.ptr)
            tcce_pkg::PTR_CLEAR: ptr_in = '0;
            tcce_pkg::PTR_INCR:  ptr_in = ptr_ff + 1'b1;
            default:             ptr_in = ptr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         ptr_ff     <= '0;
         color_ff   <= tcce_pkg::RESET_COLOR;
         bs_code_ff <= tcce_pkg::RESET_BACKSPACE;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ptr_ff <= ptr_in;
         if (csr_write) begin
            case (csr_paddr[2])
               REG_TEXT_COLOR: color_ff   <= csr_pwdata[7:0];
               REG_BACKSPACE:  bs_code_ff <= csr_pwdata[7:0];
               default:        color_ff   <= color_ff;
            endcase
         end
      end
   end

   // item fields and tab counter
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         char_ff <= req_tdata[7:0];
         addr_ff <= req_tdata[18:8];
         cnt_ff  <= CNT_W'(TAB_WIDTH - 1);
      end else if (status.exec && ctl.cnt_dec) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // screen memory: one write port, one registered read port
   // ---------------------------------------------------------------
   always_comb begin
      mem_we = 1'b0;
      mem_wa = ptr_ff;
      mem_wd = tcce_pkg::RESET_CELL;
      if (status.exec) begin
         case (ctl.wr)
            tcce_pkg::WR_RESET: begin
               mem_we = 1'b1;
            end
            tcce_pkg::WR_CHAR: begin
               mem_we = 1'b1;
               mem_wa = cur_addr;
               mem_wd = {color_ff, char_ff};
            end
            tcce_pkg::WR_SPACE: begin
               mem_we = 1'b1;
               mem_wa = cur_addr;
               mem_wd = {color_ff, tcce_pkg::CODE_SPACE};
            end
            tcce_pkg::WR_COPY: begin
               mem_we = 1'b1;
               mem_wd = rdata_ff;
            end
            tcce_pkg::WR_BLANK: begin
               mem_we = 1'b1;
               mem_wd = {color_ff, tcce_pkg::CODE_SPACE};
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   // scroll copy reads one row below the pointer
   assign mem_ra = (ctl.rd == tcce_pkg::RD_COPY) ? AW'(ptr_ff + SCREEN_WIDTH)
                                                  : AW'(addr_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= screen_mem[mem_ra];
   end

   // addresses past the screen read as zero
   assign addr_ok = ({21'd0, addr_ff} < 32'(CELLS));

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.emit) begin
         rsp_col_ff  <= 7'(col_in);
         rsp_line_ff <= 5'(row_in);
         rsp_cell_ff <= (ctl.emit_cell && addr_ok) ? rdata_ff : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_cell_ff, rsp_line_ff, rsp_col_ff};

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_TEXT_COLOR: csr_prdata = {24'd0, color_ff};
         REG_BACKSPACE:  csr_prdata = {24'd0, bs_code_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

`ifndef ASSERT_OFF
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COL_LAST) && (row_ff <= ROW_LAST))
      else $error("cursor outside the screen");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      status.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites one not yet taken");

   a_scroll_col: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr == tcce_pkg::WR_COPY) |-> (col_ff == '0))
      else $error("scroll with cursor off column zero");
`endif

endmodule
